>>> design/top_k_runtime_tracker_macros.svh
// assertion macros for the top-k runtime tracker checker
// expects clk and rst_n in the scope where a macro is used
`ifndef TOP_K_RUNTIME_TRACKER_MACROS_SVH
`define TOP_K_RUNTIME_TRACKER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TKT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TKT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/tkt_pkg.sv
// shared types and constants for the top-k runtime tracker
// no dependencies
package tkt_pkg;

    localparam int ID_W          = 22;
    localparam int DELTA_W       = 64;
    localparam int TOP_COUNT_DEF = 16;

    typedef logic [ID_W-1:0]    id_t;
    typedef logic [DELTA_W-1:0] delta_t;

    // one kept entry of the sorted chain
    typedef struct packed {
        logic   valid;
        delta_t delta;
        id_t    id;
    } entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;    // insert the pending item
        logic shift;  // move every entry one place towards the head
        logic clr;    // drop all entries
    } cell_ctl_t;

endpackage

>>> design/tkt_cell.sv
// one cell of the sorted chain: holds a single entry
// depends on tkt_pkg
module tkt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  tkt_pkg::cell_ctl_t ctl,
    input  tkt_pkg::delta_t    new_delta,
    input  tkt_pkg::id_t       new_id,
    input  tkt_pkg::entry_t    prev_q,
    input  logic               prev_take,
    input  tkt_pkg::entry_t    next_q,
    output tkt_pkg::entry_t    q,
    output logic               take
);
    import tkt_pkg::*;

    logic   valid_reg, valid_next;
    delta_t delta_reg, delta_next;
    id_t    id_reg, id_next;

    assign q    = '{valid: valid_reg, delta: delta_reg, id: id_reg};
    // strictly larger goes ahead, so an equal older entry stays in front
    assign take = !valid_reg || (new_delta > delta_reg);

    always_comb
    begin
        valid_next = valid_reg;
        delta_next = delta_reg;
        id_next    = id_reg;
        if (ctl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.ins && take)
        begin
            if (prev_take)
            begin
                valid_next = prev_q.valid;
                delta_next = prev_q.delta;
                id_next    = prev_q.id;
            end
            else
            begin
                valid_next = 1'b1;
                delta_next = new_delta;
                id_next    = new_id;
            end
        end
        else if (ctl.shift)
        begin
            valid_next = next_q.valid;
            delta_next = next_q.delta;
            id_next    = next_q.id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
        id_reg    <= id_next;
    end

endmodule

>>> design/top_k_runtime_tracker.sv
// top level of the top-k runtime tracker: front stage, cell chain and report control
// depends on tkt_pkg and tkt_cell
//
// Each accepted item (start high while busy is low) carries a task id and two
// runtime snapshots; the block forms |runtime_now - max(1, runtime_start)| and
// files the pair into a chain of TOP_COUNT cells kept in descending order, the
// head cell holding the largest difference. An item that ties an older entry
// lands behind it, and an item that falls off the tail is simply lost. Items not
// marked last are taken one per clock while busy is low. An item marked last raises
// busy from the next cycle: it is filed into the chain first, then the report runs
// while the chain shifts towards the head and the head cell is put on the result
// ports. Results come one per cycle on strobe, largest first, in the cycle after
// the head is read; final_entry marks the last one. Differences of 0 or 1 are not
// reported. The chain is emptied at the end of the report, even when nothing was
// reported. There is no back-pressure on the result side: every strobe must be
// taken in the cycle it is shown. A report holds at most TOP_COUNT results.
module top_k_runtime_tracker #(
    parameter int TOP_COUNT = tkt_pkg::TOP_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  tkt_pkg::id_t    task_id,
    input  tkt_pkg::delta_t runtime_start,
    input  tkt_pkg::delta_t runtime_now,
    input  logic            is_last,
    output logic            strobe,
    output tkt_pkg::id_t    ranked_id,
    output tkt_pkg::delta_t ranked_delta,
    output logic            final_entry
);
    import tkt_pkg::*;

    // front stage: clamped start snapshot and absolute difference
    delta_t start_clamped;
    delta_t abs_diff;
    logic   accept;

    // pending item, filed into the chain the cycle after acceptance
    logic   pend_valid_reg, pend_valid_next;
    logic   pend_last_reg, pend_last_next;
    delta_t pend_delta_reg;
    id_t    pend_id_reg;

    // report in progress
    logic   rpt_reg, rpt_next;

    // result registers
    logic   strobe_reg, strobe_next;
    logic   final_reg, final_next;
    id_t    rid_reg;
    delta_t rdelta_reg;

    // chain wiring: cell_q[TOP_COUNT] is the empty slot behind the tail
    entry_t    cell_q [0:TOP_COUNT];
    logic      take_w [0:TOP_COUNT];
    cell_ctl_t ctl;

    logic head_ok;
    logic next_ok;

    assign busy   = rpt_reg || (pend_valid_reg && pend_last_reg);
    assign accept = start && !busy;

    // a zero start snapshot counts as one
    assign start_clamped = {runtime_start[DELTA_W-1:1],
                            runtime_start[0] | ~(|runtime_start[DELTA_W-1:1])};
    assign abs_diff = (runtime_now > start_clamped) ? (runtime_now - start_clamped)
                                                    : (start_clamped - runtime_now);

    assign cell_q[TOP_COUNT] = '0;
    assign take_w[0]         = 1'b0;

    genvar g;
    generate
        for (g = 0; g < TOP_COUNT; g++)
        begin : g_cell
            entry_t prev_w;
            if (g == 0)
            begin : g_head
                assign prev_w = '0;
            end
            else
            begin : g_body
                assign prev_w = cell_q[g-1];
            end

            tkt_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .new_delta (pend_delta_reg),
                .new_id    (pend_id_reg),
                .prev_q    (prev_w),
                .prev_take (take_w[g]),
                .next_q    (cell_q[g+1]),
                .q         (cell_q[g]),
                .take      (take_w[g+1])
            );
        end
    endgenerate

    // an entry is worth reporting when it is valid and its difference exceeds one
    assign head_ok = cell_q[0].valid && (|cell_q[0].delta[DELTA_W-1:1]);
    assign next_ok = cell_q[1].valid && (|cell_q[1].delta[DELTA_W-1:1]);

    always_comb
    begin
        pend_valid_next = accept;
        pend_last_next  = accept && is_last;
        rpt_next        = rpt_reg;
        strobe_next     = 1'b0;
        final_next      = 1'b0;
        ctl             = '0;

        if (pend_valid_reg)
        begin
            ctl.ins = 1'b1;
            if (pend_last_reg)
            begin
                rpt_next = 1'b1;
            end
        end

        if (rpt_reg)
        begin
            if (head_ok)
            begin
                strobe_next = 1'b1;
                final_next  = !next_ok;
            end
            if (head_ok && next_ok)
            begin
                ctl.shift = 1'b1;
            end
            else
            begin
                // last reportable entry shown or none left: empty the chain
                ctl.clr  = 1'b1;
                rpt_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            rpt_reg        <= 1'b0;
            strobe_reg     <= 1'b0;
            final_reg      <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_last_reg  <= pend_last_next;
            rpt_reg        <= rpt_next;
            strobe_reg     <= strobe_next;
            final_reg      <= final_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_delta_reg <= abs_diff;
            pend_id_reg    <= task_id;
        end
        rid_reg    <= cell_q[0].id;
        rdelta_reg <= cell_q[0].delta;
    end

    assign strobe       = strobe_reg;
    assign final_entry  = final_reg;
    assign ranked_id    = rid_reg;
    assign ranked_delta = rdelta_reg;

endmodule

>>> design/top_k_runtime_tracker_chk.sv
// port-level checker for the top-k runtime tracker, bound to the top level
// depends on tkt_pkg and top_k_runtime_tracker_macros.svh
`include "top_k_runtime_tracker_macros.svh"

module top_k_runtime_tracker_chk (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            is_last,
    input logic            strobe,
    input tkt_pkg::delta_t ranked_delta,
    input logic            final_entry
);
    import tkt_pkg::*;

    // reported differences are never 0 or 1
    `TKT_ASSERT_NOW(a_delta_above_one, strobe, |ranked_delta[DELTA_W-1:1],
        "reported difference below two")

    // the last item of a set always starts a report
    `TKT_ASSERT_NEXT(a_last_sets_busy, start && !busy && is_last, busy,
        "busy not raised after last item")

    // a report runs without gaps until its final entry
    `TKT_ASSERT_NEXT(a_report_contiguous, strobe && !final_entry, strobe,
        "gap in report before final entry")

    // results come in non-increasing order of difference
    `TKT_ASSERT_NEXT(a_report_descending, strobe && !final_entry,
        ranked_delta <= $past(ranked_delta), "report not in descending order")

endmodule

bind top_k_runtime_tracker top_k_runtime_tracker_chk u_chk (.*);

>>> dv/tb_top_k_runtime_tracker.sv
`timescale 1ns / 100ps
// self-checking testbench for top_k_runtime_tracker: directed sets, then random ranking sets
// depends on tkt_pkg and the block itself; the rank scoreboard class is declared in this file
module tb_top_k_runtime_tracker;

    import tkt_pkg::*;

    // size of the ranking store in the block under test
    localparam int     TOP_N     = TOP_COUNT_DEF;
    localparam delta_t DELTA_MAX = '1;
    localparam id_t    ID_MAX    = '1;

    // one reported entry as the block should show it
    typedef struct packed {
        id_t    id;
        delta_t delta;
        logic   fin;
    } ranked_t;

    // ---------------------------------------------------------------------
    // rank scoreboard: mirrors the block's store and holds the reports
    // that are still to come, oldest first
    // ---------------------------------------------------------------------
    class rank_scoreboard;
        // ascending by difference, position 0 holds the smallest kept entry
        delta_t  kept_delta[TOP_N];
        id_t     kept_id[TOP_N];
        int      kept_n;
        ranked_t expected_ranks[$];
        int      errors;

        function new();
            kept_n = 0;
            errors = 0;
        endfunction

        // file an accepted item and, on the item marked last, queue the report
        function void note_task(id_t id, delta_t t_start, delta_t t_now, logic last);
            delta_t  s;
            delta_t  d;
            int      pos;
            int      i;
            int      lo;
            ranked_t r;
            s = (t_start == '0) ? delta_t'(1) : t_start;
            d = (t_now > s) ? t_now - s : s - t_now;
            // new entry goes ahead of every strictly smaller one only
            pos = 0;
            while (pos < kept_n && kept_delta[pos] < d)
                pos++;
            if (kept_n < TOP_N)
            begin
                for (i = kept_n; i > pos; i--)
                begin
                    kept_delta[i] = kept_delta[i-1];
                    kept_id[i]    = kept_id[i-1];
                end
                kept_delta[pos] = d;
                kept_id[pos]    = id;
                kept_n++;
            end
            else if (pos > 0)
            begin
                // full store: smallest entry falls out
                for (i = 0; i + 1 < pos; i++)
                begin
                    kept_delta[i] = kept_delta[i+1];
                    kept_id[i]    = kept_id[i+1];
                end
                kept_delta[pos-1] = d;
                kept_id[pos-1]    = id;
            end
            if (last)
            begin
                // lowest position that is still reported carries the final mark
                lo = -1;
                for (i = 0; i < kept_n; i++)
                    if (lo < 0 && kept_delta[i] > 1)
                        lo = i;
                for (i = kept_n - 1; i >= 0; i--)
                begin
                    if (kept_delta[i] > 1)
                    begin
                        r.id    = kept_id[i];
                        r.delta = kept_delta[i];
                        r.fin   = (i == lo);
                        expected_ranks.push_back(r);
                    end
                end
                kept_n = 0;
            end
        endfunction

        // compare one strobed result with the oldest expectation
        function void check_ranked(id_t id, delta_t delta, logic fin);
            ranked_t want;
            if (expected_ranks.size() == 0)
            begin
                $error("unexpected result: ranked_id %0h ranked_delta %0d final_entry %0b",
                       id, delta, fin);
                errors++;
                return;
            end
            want = expected_ranks.pop_front();
            if (id !== want.id)
            begin
                $error("ranked_id mismatch: expected %0h, actual %0h", want.id, id);
                errors++;
            end
            if (delta !== want.delta)
            begin
                $error("ranked_delta mismatch: expected %0d, actual %0d", want.delta, delta);
                errors++;
            end
            if (fin !== want.fin)
            begin
                $error("final_entry mismatch: expected %0b, actual %0b", want.fin, fin);
                errors++;
            end
        endfunction

        function int pending();
            return expected_ranks.size();
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ---------------------------------------------------------------------
    logic   clk           = 1'b0;
    logic   rst_n         = 1'b0;
    logic   start         = 1'b0;
    id_t    task_id       = '0;
    delta_t runtime_start = '0;
    delta_t runtime_now   = '0;
    logic   is_last       = 1'b0;

    logic   busy;
    logic   strobe;
    id_t    ranked_id;
    delta_t ranked_delta;
    logic   final_entry;

    // chance in a hundred that the sender leaves a cycle empty before an item
    int idle_pct = 10;

    rank_scoreboard sb = new();

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    top_k_runtime_tracker #(
        .TOP_COUNT(TOP_N)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .task_id      (task_id),
        .runtime_start(runtime_start),
        .runtime_now  (runtime_now),
        .is_last      (is_last),
        .strobe       (strobe),
        .ranked_id    (ranked_id),
        .ranked_delta (ranked_delta),
        .final_entry  (final_entry)
    );

    // ---------------------------------------------------------------------
    // monitor: everything is sampled at the rising edge, before the
    // nonblocking updates of that edge land
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // results first, so an item taken on the same edge cannot shadow them
            if (strobe)
                sb.check_ranked(ranked_id, ranked_delta, final_entry);
            if (start && !busy)
                sb.note_task(task_id, runtime_start, runtime_now, is_last);
        end
    end

    // ---------------------------------------------------------------------
    // driver: present one item and hold it until the block takes it
    // ---------------------------------------------------------------------
    task automatic send_task(input id_t id, input delta_t t_start, input delta_t t_now,
                             input logic last);
        // random gap before the item, start drops only here
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        task_id       <= id;
        runtime_start <= t_start;
        runtime_now   <= t_now;
        is_last       <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // runtime pair with a mix of wide, near, tied and extreme differences
    task automatic pick_runtimes(output delta_t t_start, output delta_t t_now);
        delta_t base;
        delta_t gap;
        base      = {$urandom, $urandom};
        base[63]  = 1'b0;
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                t_start = {$urandom, $urandom};
                t_now   = {$urandom, $urandom};
            end
            4, 5, 6:
            begin
                // small differences: plenty of ties and of the unreported 0 and 1
                gap     = delta_t'($urandom_range(6));
                t_start = base;
                t_now   = base + gap;
            end
            7:
            begin
                // zero start snapshot is raised to 1
                t_start = '0;
                t_now   = ($urandom_range(1) == 0) ? delta_t'($urandom_range(3)) : base;
            end
            8:
            begin
                // a few fixed differences so equal entries pile up
                gap     = delta_t'(1000 * $urandom_range(1, 3));
                t_start = base;
                t_now   = base + gap;
            end
            default:
            begin
                t_start = ($urandom_range(1) == 0) ? '0 : DELTA_MAX;
                case ($urandom_range(2))
                    0:       t_now = '0;
                    1:       t_now = DELTA_MAX;
                    default: t_now = delta_t'(1);
                endcase
            end
        endcase
        // either order of the two snapshots
        if ($urandom_range(1) == 0)
        begin
            base    = t_start;
            t_start = t_now;
            t_now   = base;
        end
    endtask

    // random ranking sets, each closed by an item marked last
    task automatic run_sets(input int pct, input int budget);
        int     len;
        int     k;
        delta_t t_start;
        delta_t t_now;
        idle_pct = pct;
        while (budget > 0)
        begin
            // now and then a set long enough to overflow the store
            len = ($urandom_range(3) == 0) ? $urandom_range(TOP_N + 1, 2 * TOP_N)
                                           : $urandom_range(1, 10);
            for (k = 0; k < len; k++)
            begin
                pick_runtimes(t_start, t_now);
                send_task(id_t'($urandom), t_start, t_now, k == len - 1);
            end
            budget -= len;
        end
    endtask

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    initial
    begin : stimulus
        int k;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes: zero start raised to 1, near full-range differences,
        // the smallest reported difference and a difference of 1 that is skipped
        send_task('0, '0, '0, 1'b0);
        send_task(ID_MAX, DELTA_MAX, '0, 1'b0);
        send_task(id_t'(1), '0, DELTA_MAX, 1'b0);
        send_task(id_t'(2), delta_t'(2), delta_t'(4), 1'b1);

        // report with nothing to show: lone item with a difference of 0
        send_task(id_t'(5), DELTA_MAX, DELTA_MAX, 1'b1);

        // fill the store, then offer a smaller value and one equal to the smallest;
        // neither may get in
        for (k = 0; k < TOP_N; k++)
            send_task(id_t'(16 + k), delta_t'(1000), delta_t'(1100 + k), 1'b0);
        send_task(id_t'(40), delta_t'(1000), delta_t'(1050), 1'b0);
        send_task(id_t'(41), delta_t'(500), delta_t'(400), 1'b0);
        send_task(id_t'(42), '0, delta_t'(1001), 1'b1);

        // random sets under three idling patterns
        run_sets(10, 150);
        run_sets(67, 150);
        run_sets(0, 150);
        start <= 1'b0;

        // drain outstanding reports, then keep the clock running for stray strobes
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2 * TOP_N + 4) @(posedge clk);

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/tkt_pkg.sv
design/tkt_cell.sv
design/top_k_runtime_tracker.sv
design/top_k_runtime_tracker_chk.sv
dv/tb_top_k_runtime_tracker.sv
